// ===== hdl/tlvv_pkg.sv =====
package tlvv_pkg;

    // Stack geometry
    localparam int MAX_NESTING = 16;
    localparam int STACK_SIZE  = MAX_NESTING + 1;
    localparam int LVL_W       = $clog2(STACK_SIZE + 1);
    localparam int ADDR_W      = $clog2(STACK_SIZE);

    // Payload geometry
    localparam int POS_W = 24;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] MIN_PAYLOAD = 24'd10;

    localparam logic [7:0] MAGIC_BYTES [4] = '{8'h4A, 8'h41, 8'h53, 8'h4C};
    localparam logic [7:0] VERSION_BYTE = 8'd1;

    // Value type codes
    localparam logic [2:0] TYPE_OCTETS = 3'd3;
    localparam logic [2:0] TYPE_OPAQUE = 3'd4;
    localparam logic [2:0] TYPE_LIST   = 3'd5;
    localparam logic [2:0] TYPE_MAP    = 3'd6;
    localparam logic [2:0] TYPE_BAD    = 3'd7;
    localparam logic [2:0] TYPE_EMPTY_MAX = 3'd2;

    // Error flag bits
    localparam int FL_SIZE   = 0;
    localparam int FL_STRUCT = 1;
    localparam int FL_TRAIL  = 2;

    // Verdict codes
    localparam logic [1:0] VERDICT_OK     = 2'd0;
    localparam logic [1:0] VERDICT_SIZE   = 2'd1;
    localparam logic [1:0] VERDICT_STRUCT = 2'd2;
    localparam logic [1:0] VERDICT_TRAIL  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_MAX_ENTRY   = 1'b0;
    localparam logic CFG_MAX_PAYLOAD = 1'b1;

    localparam logic [15:0]    MAX_ENTRY_RESET   = 16'd4096;
    localparam logic [POS_W-1:0] MAX_PAYLOAD_RESET = 24'd8388608;

    typedef enum logic [7:0] {
        PH_MAGIC   = 8'b0000_0001,
        PH_VHDR    = 8'b0000_0010,
        PH_COUNT   = 8'b0000_0100,
        PH_KEYLEN  = 8'b0000_1000,
        PH_SKIPKEY = 8'b0001_0000,
        PH_SKIPVAL = 8'b0010_0000,
        PH_TRAIL   = 8'b0100_0000,
        PH_IDLE    = 8'b1000_0000
    } phase_t;

    typedef enum logic [2:0] {
        SQ_IN     = 3'b001,
        SQ_POP_RD = 3'b010,
        SQ_POP_LD = 3'b100
    } seq_t;

    typedef struct packed {
        logic [POS_W-1:0] cend;
        logic [15:0]      left;
        logic             is_map;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic       valid;
        logic [1:0] verdict;
    } result_t;

endpackage

// ===== hdl/nested_tlv_payload_validator.sv =====
// Validates a nested type-length-value payload streamed one byte per beat and
// returns one verdict beat after the beat flagged last (0 valid, 1 size/magic/
// version, 2 structure, 3 trailing bytes). Every nested container that closes
// (any container but the root) stalls the input while its parent entry is
// fetched from the stack RAM through its registered read port (POP_RD, then
// POP_LD); cascaded closes each repeat this pop, and a verdict whose last
// beat closes containers follows those pops. A new byte is taken only while
// the verdict register is free or being drained. The two limit registers are
// written through the cfg port.
module nested_tlv_payload_validator
    import tlvv_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,
    input  logic             s_last_byte,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_verdict,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [POS_W-1:0] cfg_wdata
);

    logic [15:0]      max_entry_reg;
    logic [POS_W-1:0] max_payload_reg;
    logic             m_valid_reg;
    logic [1:0]       m_verdict_reg;
    logic             core_ready;
    logic             beat_acc;
    result_t          result;

    assign s_ready  = core_ready && (!m_valid_reg || m_ready);
    assign beat_acc = s_valid && s_ready;

    tlvv_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_acc    (beat_acc),
        .data_byte   (s_data_byte),
        .last_byte   (s_last_byte),
        .max_entry   (max_entry_reg),
        .max_payload (max_payload_reg),
        .core_ready  (core_ready),
        .result      (result)
    );

    // Hold limit registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entry_reg   <= MAX_ENTRY_RESET;
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end else if (cfg_we) begin
            if (cfg_index == CFG_MAX_ENTRY) begin
                max_entry_reg <= cfg_wdata[15:0];
            end else begin
                max_payload_reg <= cfg_wdata;
            end
        end
    end

    // Hold the verdict beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.valid) begin
            m_verdict_reg <= result.verdict;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_verdict = m_verdict_reg;

endmodule

// ===== hdl/tlvv_ram.sv =====
module tlvv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/tlvv_core.sv =====
module tlvv_core
    import tlvv_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             beat_acc,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    input  logic [15:0]      max_entry,
    input  logic [POS_W-1:0] max_payload,
    output logic             core_ready,
    output result_t          result
);

    logic [POS_W-1:0] pos_reg, pos_next;
    phase_t           phase_reg, phase_next;
    logic [2:0]       fidx_reg, fidx_next;
    logic [2:0]       ctype_reg, ctype_next;
    logic [31:0]      lacc_reg, lacc_next;
    logic [31:0]      skip_reg, skip_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic [2:0]       err_reg, err_next;
    entry_t           top_reg, top_next;
    seq_t             seq_reg, seq_next;
    logic             lastp_reg, lastp_next;

    logic             ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    entry_t           ram_wdata, ram_rdata;

    logic [POS_W-1:0] o;
    logic [POS_W-1:0] e;
    logic [31:0]      len32;
    logic [32:0]      root_end;
    logic [15:0]      cnt;
    logic             start_go, child_go, cont_go, count_go, pop_req, fin;
    logic [POS_W:0]   plen;
    logic [1:0]       verdict;

    tlvv_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_SIZE)
    ) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign core_ready = (seq_reg == SQ_IN);

    // Parse one byte, or resume after a stack pop
    always_comb begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        fidx_next  = fidx_reg;
        ctype_next = ctype_reg;
        lacc_next  = lacc_reg;
        skip_next  = skip_reg;
        lvl_next   = lvl_reg;
        err_next   = err_reg;
        top_next   = top_reg;
        seq_next   = seq_reg;
        lastp_next = lastp_reg;
        ram_we     = 1'b0;
        ram_waddr  = ADDR_W'(lvl_reg - 1'b1);
        ram_wdata  = top_reg;
        ram_raddr  = ADDR_W'(lvl_reg - 1'b1);
        start_go   = 1'b0;
        child_go   = 1'b0;
        cont_go    = 1'b0;
        count_go   = 1'b0;
        pop_req    = 1'b0;
        fin        = 1'b0;
        verdict    = VERDICT_OK;
        o          = (seq_reg == SQ_IN) ? pos_reg + 1'b1 : pos_reg;
        e          = (lvl_reg != '0) ? top_reg.cend : '0;
        len32      = {lacc_reg[23:0], data_byte};
        root_end   = {9'd0, o} + {1'b0, len32};
        cnt        = {skip_reg[7:0], data_byte};
        plen       = '0;

        if (beat_acc) begin
            lastp_next = last_byte;
            if (pos_reg == POS_MAX) begin
                err_next[FL_SIZE] = 1'b1;
                phase_next = PH_IDLE;
            end else begin
                pos_next = pos_reg + 1'b1;
                unique case (phase_reg)
                    PH_MAGIC: begin
                        if (pos_reg < POS_W'(4)) begin
                            if (data_byte != MAGIC_BYTES[pos_reg[1:0]]) begin
                                err_next[FL_SIZE] = 1'b1;
                                phase_next = PH_IDLE;
                            end
                        end else if (pos_reg == POS_W'(4)) begin
                            if (data_byte != VERSION_BYTE) begin
                                err_next[FL_SIZE] = 1'b1;
                                phase_next = PH_IDLE;
                            end else begin
                                start_go = 1'b1;
                            end
                        end else begin
                            err_next[FL_SIZE] = 1'b1;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_VHDR: begin
                        if (fidx_reg == 3'd0) begin
                            ctype_next = (data_byte > 8'd6) ? TYPE_BAD : data_byte[2:0];
                            if (lvl_reg == '0 && data_byte != {5'd0, TYPE_MAP}) begin
                                err_next[FL_STRUCT] = 1'b1;
                                phase_next = PH_IDLE;
                            end else begin
                                fidx_next = 3'd1;
                            end
                        end else begin
                            lacc_next = len32;
                            if (fidx_reg >= 3'd4) begin
                                // Header complete: check fit, then dispatch on type
                                if ((lvl_reg != '0 && (o > e || len32 > {8'd0, e - o})) ||
                                    (lvl_reg == '0 && root_end > {9'd0, POS_MAX})) begin
                                    err_next[FL_STRUCT] = 1'b1;
                                    phase_next = PH_IDLE;
                                end else if (ctype_reg <= TYPE_EMPTY_MAX) begin
                                    if (len32 != '0) begin
                                        err_next[FL_STRUCT] = 1'b1;
                                        phase_next = PH_IDLE;
                                    end else begin
                                        child_go = 1'b1;
                                    end
                                end else if (ctype_reg == TYPE_OCTETS) begin
                                    if (len32 != 32'd4) begin
                                        err_next[FL_STRUCT] = 1'b1;
                                        phase_next = PH_IDLE;
                                    end else begin
                                        skip_next = 32'd4;
                                        phase_next = PH_SKIPVAL;
                                    end
                                end else if (ctype_reg == TYPE_OPAQUE) begin
                                    if (len32 == '0) begin
                                        child_go = 1'b1;
                                    end else begin
                                        skip_next = len32;
                                        phase_next = PH_SKIPVAL;
                                    end
                                end else if (ctype_reg == TYPE_LIST || ctype_reg == TYPE_MAP) begin
                                    if (len32 < 32'd2) begin
                                        err_next[FL_STRUCT] = 1'b1;
                                        phase_next = PH_IDLE;
                                    end else begin
                                        phase_next = PH_COUNT;
                                        fidx_next = 3'd0;
                                        skip_next = '0;
                                    end
                                end else begin
                                    err_next[FL_STRUCT] = 1'b1;
                                    phase_next = PH_IDLE;
                                end
                            end else begin
                                fidx_next = fidx_reg + 1'b1;
                            end
                        end
                    end
                    PH_COUNT: begin
                        skip_next = {16'd0, cnt};
                        if (fidx_reg >= 3'd1) begin
                            count_go = 1'b1;
                        end else begin
                            fidx_next = 3'd1;
                        end
                    end
                    PH_KEYLEN: begin
                        if (data_byte == 8'd0 || o > e || {16'd0, data_byte} > e - o) begin
                            err_next[FL_STRUCT] = 1'b1;
                            phase_next = PH_IDLE;
                        end else begin
                            skip_next = {24'd0, data_byte};
                            phase_next = PH_SKIPKEY;
                        end
                    end
                    PH_SKIPKEY: begin
                        if (skip_reg != '0) begin
                            skip_next = skip_reg - 1'b1;
                        end
                        if (skip_next == '0) begin
                            start_go = 1'b1;
                        end
                    end
                    PH_SKIPVAL: begin
                        if (skip_reg != '0) begin
                            skip_next = skip_reg - 1'b1;
                        end
                        if (skip_next == '0) begin
                            child_go = 1'b1;
                        end
                    end
                    PH_TRAIL: begin
                        err_next[FL_TRAIL] = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    PH_IDLE: begin
                    end
                    default: begin
                    end
                endcase
            end
        end else if (seq_reg == SQ_POP_RD) begin
            seq_next = SQ_POP_LD;
        end else if (seq_reg == SQ_POP_LD) begin
            // Parent entry arrives: it becomes the top, one element done
            top_next = ram_rdata;
            if (ram_rdata.left != '0) begin
                top_next.left = ram_rdata.left - 1'b1;
            end
            cont_go = 1'b1;
        end

        // Open a container: spill the old top, install the new one
        if (count_go) begin
            if (skip_next[15:0] > max_entry || lvl_reg >= LVL_W'(STACK_SIZE)) begin
                err_next[FL_STRUCT] = 1'b1;
                phase_next = PH_IDLE;
            end else begin
                ram_we = (lvl_reg != '0);
                top_next.cend = o - POS_W'(2) + lacc_reg[POS_W-1:0];
                top_next.left = skip_next[15:0];
                top_next.is_map = (ctype_reg == TYPE_MAP);
                lvl_next = lvl_reg + 1'b1;
                skip_next = '0;
                cont_go = 1'b1;
            end
        end

        // Child finished: count it against the parent
        if (child_go) begin
            if (lvl_next == '0) begin
                phase_next = PH_TRAIL;
            end else begin
                if (top_next.left != '0) begin
                    top_next.left = top_next.left - 1'b1;
                end
                cont_go = 1'b1;
            end
        end

        // Next element of the top container, or close it
        if (cont_go) begin
            if (lvl_next == '0) begin
                phase_next = PH_TRAIL;
            end else if (top_next.left != '0) begin
                if (top_next.is_map) begin
                    if (o >= top_next.cend) begin
                        err_next[FL_STRUCT] = 1'b1;
                        phase_next = PH_IDLE;
                    end else begin
                        phase_next = PH_KEYLEN;
                    end
                end else begin
                    start_go = 1'b1;
                end
            end else if (top_next.cend != o) begin
                err_next[FL_STRUCT] = 1'b1;
                phase_next = PH_IDLE;
            end else begin
                lvl_next = lvl_next - 1'b1;
                if (lvl_next == '0) begin
                    phase_next = PH_TRAIL;
                end else begin
                    pop_req = 1'b1;
                end
            end
        end

        // Begin a value header
        if (start_go) begin
            if (lvl_next > LVL_W'(MAX_NESTING)) begin
                err_next[FL_STRUCT] = 1'b1;
                phase_next = PH_IDLE;
            end else if (lvl_next != '0 &&
                         (o > top_next.cend || top_next.cend - o < POS_W'(5))) begin
                err_next[FL_STRUCT] = 1'b1;
                phase_next = PH_IDLE;
            end else begin
                phase_next = PH_VHDR;
                fidx_next = 3'd0;
                lacc_next = '0;
            end
        end

        if (pop_req) begin
            seq_next = SQ_POP_RD;
        end else if (seq_reg == SQ_POP_LD) begin
            seq_next = SQ_IN;
        end

        // Verdict on the final beat once all pops are done
        fin = !pop_req && ((beat_acc && last_byte) || (seq_reg == SQ_POP_LD && lastp_reg));
        plen = (pos_reg == POS_MAX && beat_acc) ? {1'b1, {POS_W{1'b0}}} : {1'b0, pos_next};
        if (err_next[FL_SIZE] || plen < {1'b0, MIN_PAYLOAD} || plen > {1'b0, max_payload}) begin
            verdict = VERDICT_SIZE;
        end else if (err_next[FL_STRUCT] || (phase_next != PH_TRAIL && !err_next[FL_TRAIL])) begin
            verdict = VERDICT_STRUCT;
        end else if (err_next[FL_TRAIL]) begin
            verdict = VERDICT_TRAIL;
        end else begin
            verdict = VERDICT_OK;
        end

        if (fin) begin
            pos_next   = '0;
            phase_next = PH_MAGIC;
            fidx_next  = '0;
            ctype_next = '0;
            lacc_next  = '0;
            skip_next  = '0;
            lvl_next   = '0;
            err_next   = '0;
            seq_next   = SQ_IN;
            lastp_next = 1'b0;
        end
    end

    assign result.valid   = fin;
    assign result.verdict = verdict;

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            phase_reg <= PH_MAGIC;
            fidx_reg  <= '0;
            ctype_reg <= '0;
            lacc_reg  <= '0;
            skip_reg  <= '0;
            lvl_reg   <= '0;
            err_reg   <= '0;
            seq_reg   <= SQ_IN;
            lastp_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            fidx_reg  <= fidx_next;
            ctype_reg <= ctype_next;
            lacc_reg  <= lacc_next;
            skip_reg  <= skip_next;
            lvl_reg   <= lvl_next;
            err_reg   <= err_next;
            seq_reg   <= seq_next;
            lastp_reg <= lastp_next;
        end
    end

    // Top of stack cache
    always_ff @(posedge aclk) begin
        top_reg <= top_next;
    end

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        lvl_reg <= LVL_W'(STACK_SIZE))
        else $error("stack level out of range");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg == SQ_POP_RD |-> lvl_reg != '0)
        else $error("pop read with empty stack");

    a_pop_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg == SQ_POP_RD |=> seq_reg == SQ_POP_LD)
        else $error("pop read not followed by load");

    a_no_beat_in_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg != SQ_IN |-> !beat_acc)
        else $error("beat accepted during pop");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb
    import tlvv_pkg::*;
();

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [7:0]       s_data_byte;
    logic             s_last_byte;
    logic             m_valid;
    logic             m_ready;
    logic [1:0]       m_verdict;
    logic             cfg_we;
    logic             cfg_index;
    logic [POS_W-1:0] cfg_wdata;

    nested_tlv_payload_validator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_data_byte(s_data_byte), .s_last_byte(s_last_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_verdict(m_verdict),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 80;

    // Type bytes as they appear in a payload
    localparam logic [7:0] B_OCTETS = {5'd0, TYPE_OCTETS};
    localparam logic [7:0] B_OPAQUE = {5'd0, TYPE_OPAQUE};
    localparam logic [7:0] B_LIST   = {5'd0, TYPE_LIST};
    localparam logic [7:0] B_MAP    = {5'd0, TYPE_MAP};

    // Parser phases of the predictor
    typedef enum int {
        P_MAGIC, P_VHDR, P_COUNT, P_KEYLEN, P_SKIPKEY, P_SKIPVAL, P_TRAIL, P_IDLE
    } pphase_t;

    // Predictor state
    logic [15:0]      lim_entries;
    logic [POS_W-1:0] lim_bytes;
    logic [31:0]      pos;
    pphase_t          phase;
    int unsigned      fidx;
    logic [2:0]       vtype;
    logic [31:0]      len_acc;
    logic [31:0]      skip_cnt;
    logic [31:0]      stk_end [STACK_SIZE];
    logic [15:0]      stk_left [STACK_SIZE];
    logic             stk_map [STACK_SIZE];
    int unsigned      depth;
    logic             f_size, f_struct, f_trail;

    logic [1:0] verdict_q [$];
    int         err_count;
    int         cycle_count;
    int         s_idle_pct, m_idle_pct;

    function automatic void clear_parser();
        pos = 0; phase = P_MAGIC; fidx = 0; vtype = 0; len_acc = 0; skip_cnt = 0;
        depth = 0; f_size = 0; f_struct = 0; f_trail = 0;
        for (int i = 0; i < STACK_SIZE; i++) begin
            stk_end[i] = 0; stk_left[i] = 0; stk_map[i] = 0;
        end
    endfunction

    function automatic void set_fault(bit is_size);
        if (is_size) f_size = 1; else f_struct = 1;
        phase = P_IDLE;
    endfunction

    function automatic void open_value(logic [31:0] o);
        logic [31:0] e;
        if (depth > MAX_NESTING) begin
            set_fault(0);
            return;
        end
        if (depth > 0) begin
            e = stk_end[depth-1];
            if (o > e || e - o < 5) begin
                set_fault(0);
                return;
            end
        end
        phase = P_VHDR; fidx = 0; len_acc = 0;
    endfunction

    // Move on to the next element, or close finished containers
    function automatic void advance_container(logic [31:0] o);
        int unsigned t;
        forever begin
            if (depth == 0 || depth > STACK_SIZE) begin
                phase = P_TRAIL;
                return;
            end
            t = depth - 1;
            if (stk_left[t] != 0) begin
                if (stk_map[t]) begin
                    if (o >= stk_end[t]) set_fault(0);
                    else phase = P_KEYLEN;
                end else begin
                    open_value(o);
                end
                return;
            end
            if (stk_end[t] != o) begin
                set_fault(0);
                return;
            end
            depth--;
            if (depth == 0) begin
                phase = P_TRAIL;
                return;
            end
            if (stk_left[depth-1] != 0) stk_left[depth-1]--;
        end
    endfunction

    function automatic void element_done(logic [31:0] o);
        if (depth == 0 || depth > STACK_SIZE) begin
            phase = P_TRAIL;
            return;
        end
        if (stk_left[depth-1] != 0) stk_left[depth-1]--;
        advance_container(o);
    endfunction

    function automatic void header_done(logic [31:0] o);
        logic [31:0] e;
        logic [32:0] end_pos;
        end_pos = {1'b0, o} + {1'b0, len_acc};
        if (depth > 0) begin
            e = stk_end[depth-1];
            if (o > e || len_acc > e - o) begin
                set_fault(0);
                return;
            end
        end else if (end_pos > {9'd0, POS_MAX}) begin
            set_fault(0);
            return;
        end
        if (vtype <= TYPE_EMPTY_MAX) begin
            if (len_acc != 0) set_fault(0);
            else element_done(o);
        end else if (vtype == TYPE_OCTETS) begin
            if (len_acc != 4) set_fault(0);
            else begin
                skip_cnt = 4; phase = P_SKIPVAL;
            end
        end else if (vtype == TYPE_OPAQUE) begin
            if (len_acc == 0) element_done(o);
            else begin
                skip_cnt = len_acc; phase = P_SKIPVAL;
            end
        end else if (vtype == TYPE_LIST || vtype == TYPE_MAP) begin
            if (len_acc < 2) set_fault(0);
            else begin
                phase = P_COUNT; fidx = 0; skip_cnt = 0;
            end
        end else begin
            set_fault(0);
        end
    endfunction

    function automatic void count_done(logic [31:0] o);
        logic [15:0] cnt;
        logic [32:0] end_pos;
        cnt = skip_cnt[15:0];
        if (cnt > lim_entries || depth >= STACK_SIZE) begin
            set_fault(0);
            return;
        end
        end_pos = {1'b0, o} - 33'd2 + {1'b0, len_acc};
        stk_end[depth] = {8'd0, end_pos[23:0]};
        stk_left[depth] = cnt;
        stk_map[depth] = (vtype == TYPE_MAP);
        depth++;
        skip_cnt = 0;
        advance_container(o);
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic [31:0] idx);
        logic [31:0] o, e;
        o = idx + 1;
        case (phase)
            P_MAGIC: begin
                if (idx < 4) begin
                    if (b != MAGIC_BYTES[idx]) set_fault(1);
                end else if (idx == 4) begin
                    if (b != VERSION_BYTE) set_fault(1);
                    else open_value(o);
                end else begin
                    set_fault(1);
                end
            end
            P_VHDR: begin
                if (fidx == 0) begin
                    vtype = (b > 6) ? TYPE_BAD : b[2:0];
                    if (depth == 0 && b != B_MAP) set_fault(0);
                    else fidx = 1;
                end else begin
                    len_acc = {len_acc[23:0], b};
                    if (fidx >= 4) header_done(o);
                    else fidx++;
                end
            end
            P_COUNT: begin
                skip_cnt = {16'd0, skip_cnt[7:0], b};
                if (fidx >= 1) count_done(o);
                else fidx = 1;
            end
            P_KEYLEN: begin
                e = (depth > 0 && depth <= STACK_SIZE) ? stk_end[depth-1] : 0;
                if (b == 0 || o > e || {24'd0, b} > e - o) set_fault(0);
                else begin
                    skip_cnt = {24'd0, b}; phase = P_SKIPKEY;
                end
            end
            P_SKIPKEY: begin
                if (skip_cnt != 0) skip_cnt--;
                if (skip_cnt == 0) open_value(o);
            end
            P_SKIPVAL: begin
                if (skip_cnt != 0) skip_cnt--;
                if (skip_cnt == 0) element_done(o);
            end
            P_TRAIL: begin
                f_trail = 1; phase = P_IDLE;
            end
            default: ;
        endcase
    endfunction

    // Advance the predictor by one beat; queue a verdict on the last one
    function automatic void predict_beat(logic [7:0] b, logic last);
        logic [31:0] idx, plen;
        logic [1:0]  v;
        idx = pos;
        if (idx >= POS_MAX) set_fault(1);
        else begin
            pos = idx + 1;
            parse_byte(b, idx);
        end
        if (last) begin
            plen = idx + 1;
            if (f_size || plen < MIN_PAYLOAD || plen > lim_bytes) v = VERDICT_SIZE;
            else if (f_struct || (phase != P_TRAIL && !f_trail)) v = VERDICT_STRUCT;
            else if (f_trail) v = VERDICT_TRAIL;
            else v = VERDICT_OK;
            verdict_q.push_back(v);
            clear_parser();
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        err_count++;
    endtask

    // Clock and cycle limit
    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Check verdict beats and drive receiver backpressure
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) report_mismatch("verdict with none expected");
            else begin
                if (m_verdict !== verdict_q[0])
                    report_mismatch($sformatf("verdict %0d, expected %0d",
                                              m_verdict, verdict_q[0]));
                void'(verdict_q.pop_front());
            end
        end
        m_ready <= ($urandom_range(99) >= m_idle_pct);
    end

    // Payload under construction
    logic [7:0] pkt [$];

    // Present one beat and hold it until accepted; valid stays up afterwards
    task automatic send_beat(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1; s_data_byte <= b; s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_beat(b, last);
    endtask

    task automatic send_packet(input int want);
        for (int i = 0; i < pkt.size(); i++) begin
            send_beat(pkt[i], i == pkt.size() - 1);
            if (i == pkt.size() - 1 && want >= 0 && verdict_q[$] !== want[1:0])
                report_mismatch($sformatf("table row predicts %0d, typed %0d",
                                          verdict_q[$], want));
        end
    endtask

    // Drop valid, then wait for every verdict to drain
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [POS_W-1:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_MAX_ENTRY) lim_entries = val[15:0];
        else lim_bytes = val;
        @(posedge aclk);
    endtask

    // Packet builders
    function automatic void put_hdr(logic [7:0] t, logic [31:0] l);
        pkt.push_back(t);
        for (int i = 3; i >= 0; i--) pkt.push_back(l[i*8 +: 8]);
    endfunction

    function automatic void put_prologue();
        pkt = {};
        foreach (MAGIC_BYTES[i]) pkt.push_back(MAGIC_BYTES[i]);
        pkt.push_back(VERSION_BYTE);
    endfunction

    // Append a random well-formed value; returns bytes appended
    function automatic int put_value(int lvl, bit map_only);
        int start, n, t;
        int hpos;
        logic [31:0] body;
        start = pkt.size();
        t = map_only ? 6 : ((lvl >= 4) ? $urandom_range(4) : $urandom_range(6));
        if (lvl > 0 && !map_only && $urandom_range(9) == 0 && lvl < 3) t = 6;
        hpos = pkt.size();
        put_hdr(8'(t), 32'd0);
        if (t <= 2) return pkt.size() - start;
        if (t == 3) begin
            repeat (4) pkt.push_back(8'($urandom));
        end else if (t == 4) begin
            n = $urandom_range(3) == 0 ? 0 : $urandom_range(1, 6);
            repeat (n) pkt.push_back(8'($urandom));
        end else begin
            n = $urandom_range(3);
            pkt.push_back(8'(n >> 8)); pkt.push_back(8'(n));
            for (int i = 0; i < n; i++) begin
                if (t == 6) begin
                    int kl;
                    kl = $urandom_range(1, 3);
                    pkt.push_back(8'(kl));
                    repeat (kl) pkt.push_back(8'($urandom));
                end
                void'(put_value(lvl + 1, 0));
            end
        end
        body = pkt.size() - hpos - 5;
        for (int i = 0; i < 4; i++) pkt[hpos + 1 + i] = body[(3-i)*8 +: 8];
        return pkt.size() - start;
    endfunction

    // Directed table
    typedef enum int {
        K_MIN_MAP, K_BAD_MAGIC, K_SHORT, K_TRAIL, K_TRUNC, K_BAD_TYPE,
        K_BAD_VERSION, K_ALL_TYPES, K_DEEP, K_ZERO_KEY, K_BIG_ROOT,
        K_BIG_COUNT, K_ALL_FF
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        int          want;   // -1 = from predictor
    } drow_t;

    drow_t dir_rows [] = '{
        '{K_MIN_MAP, VERDICT_OK}, '{K_BAD_MAGIC, VERDICT_SIZE}, '{K_SHORT, VERDICT_SIZE},
        '{K_TRAIL, VERDICT_TRAIL}, '{K_TRUNC, VERDICT_STRUCT}, '{K_BAD_TYPE, VERDICT_STRUCT},
        '{K_BAD_VERSION, VERDICT_SIZE}, '{K_ALL_TYPES, VERDICT_OK}, '{K_DEEP, -1},
        '{K_ZERO_KEY, VERDICT_STRUCT}, '{K_BIG_ROOT, VERDICT_STRUCT}, '{K_BIG_COUNT, -1},
        '{K_ALL_FF, VERDICT_SIZE}, '{K_DEEP, -1}
    };

    function automatic void build_row(row_kind_t kind, bit variant);
        int hpos;
        logic [31:0] body;
        put_prologue();
        case (kind)
            K_MIN_MAP, K_TRAIL, K_TRUNC: begin
                put_hdr(B_MAP, 32'd2); pkt.push_back(8'd0); pkt.push_back(8'd0);
                if (kind == K_TRAIL) pkt.push_back(8'h00);
                if (kind == K_TRUNC) void'(pkt.pop_back());
            end
            K_BAD_MAGIC: begin
                pkt[0] = 8'hB5;
                put_hdr(B_MAP, 32'd2); pkt.push_back(8'd0); pkt.push_back(8'd0);
            end
            K_SHORT: pkt.push_back(B_MAP);
            K_BAD_TYPE: begin
                put_hdr(B_MAP, 32'd10); pkt.push_back(8'd0); pkt.push_back(8'd1);
                pkt.push_back(8'd1); pkt.push_back(8'h41); put_hdr(8'hFF, 32'd0);
            end
            K_BAD_VERSION: begin
                pkt[4] = 8'hFE;
                put_hdr(B_MAP, 32'd2); pkt.push_back(8'd0); pkt.push_back(8'd0);
            end
            K_ALL_TYPES: begin
                // Map holding one list with one element of each type but list
                hpos = pkt.size(); put_hdr(B_MAP, 32'd0);
                pkt.push_back(8'd0); pkt.push_back(8'd1);
                pkt.push_back(8'd1); pkt.push_back(8'h6B);
                put_hdr(B_LIST, 32'(2 + 3*5 + 9 + 8 + 7));
                pkt.push_back(8'd0); pkt.push_back(8'd6);
                for (int t = 0; t <= 2; t++) put_hdr(8'(t), 32'd0);
                put_hdr(B_OCTETS, 32'd4); repeat (4) pkt.push_back(8'hA5);
                put_hdr(B_OPAQUE, 32'd3); repeat (3) pkt.push_back(8'h5A);
                put_hdr(B_MAP, 32'd2); pkt.push_back(8'd0); pkt.push_back(8'd0);
                body = pkt.size() - hpos - 5;
                for (int i = 0; i < 4; i++) pkt[hpos + 1 + i] = body[(3-i)*8 +: 8];
            end
            K_DEEP: begin
                // Root map, then a chain of single-element lists
                int lv, starts[$];
                lv = variant ? 17 : 15;
                put_hdr(B_MAP, 32'd0); starts.push_back(5);
                pkt.push_back(8'd0); pkt.push_back(8'd1);
                pkt.push_back(8'd1); pkt.push_back(8'h6B);
                for (int i = 0; i < lv; i++) begin
                    starts.push_back(pkt.size());
                    put_hdr(B_LIST, 32'd0); pkt.push_back(8'd0); pkt.push_back(8'd1);
                end
                put_hdr(8'd0, 32'd0);
                foreach (starts[i]) begin
                    body = pkt.size() - starts[i] - 5;
                    for (int k = 0; k < 4; k++) pkt[starts[i] + 1 + k] = body[(3-k)*8 +: 8];
                end
            end
            K_ZERO_KEY: begin
                put_hdr(B_MAP, 32'd9); pkt.push_back(8'd0); pkt.push_back(8'd1);
                pkt.push_back(8'd0); put_hdr(8'd0, 32'd0);
            end
            K_BIG_ROOT: begin
                put_hdr(B_MAP, 32'hFFFFFFFF); pkt.push_back(8'd0); pkt.push_back(8'd0);
            end
            K_BIG_COUNT: begin
                put_hdr(B_MAP, 32'd2); pkt.push_back(8'hFF); pkt.push_back(8'hFF);
            end
            default: begin
                pkt = {};
                repeat (12) pkt.push_back(8'hFF);
            end
        endcase
    endfunction

    // Random payload: mostly well formed, some damaged
    function automatic void build_random();
        int r, n;
        r = $urandom_range(99);
        if (r < 8) begin
            pkt = {};
            n = $urandom_range(1, 14);
            repeat (n) pkt.push_back(8'($urandom));
            return;
        end
        put_prologue();
        void'(put_value(0, 1));
        if (r < 70) return;
        n = $urandom_range(pkt.size() - 1);
        if (r < 80) pkt[n] = 8'($urandom);
        else if (r < 87) pkt[n] = pkt[n] ^ (8'h1 << $urandom_range(7));
        else if (r < 93) begin
            while (pkt.size() > n + 1) void'(pkt.pop_back());
        end else begin
            repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
        end
    endfunction

    int beats;

    initial begin
        s_valid = 0; s_data_byte = 0; s_last_byte = 0; m_ready = 0;
        cfg_we = 0; cfg_index = CFG_MAX_ENTRY; cfg_wdata = 0;
        err_count = 0; cycle_count = 0; s_idle_pct = 28; m_idle_pct = 60;
        lim_entries = MAX_ENTRY_RESET; lim_bytes = MAX_PAYLOAD_RESET;
        clear_parser();
        aresetn = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows at reset limits, then minimal maps and a big count with tight limits
        foreach (dir_rows[i]) begin
            build_row(dir_rows[i].kind, i == dir_rows.size() - 1);
            send_packet(dir_rows[i].want);
        end
        wait_idle();
        write_reg(CFG_MAX_ENTRY, 24'hFFFF);
        write_reg(CFG_MAX_PAYLOAD, 24'd10);
        for (int k = 0; k < 3; k++) begin
            if (k == 2) build_row(K_BIG_COUNT, 1'b0);
            else build_row(K_MIN_MAP, 1'b0);
            send_packet(-1);
        end
        wait_idle();
        write_reg(CFG_MAX_ENTRY, 24'd0);
        write_reg(CFG_MAX_PAYLOAD, POS_MAX);
        build_row(K_ALL_TYPES, 1'b0);
        send_packet(-1);
        build_row(K_MIN_MAP, 1'b0);
        send_packet(VERDICT_OK);

        // Random phases with changing idle patterns and limits
        beats = 0;
        for (int ph = 0; ph < 3; ph++) begin
            wait_idle();
            s_idle_pct = (ph == 0) ? 28 : (ph == 1) ? 60 : 0;
            m_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 28 : 0;
            write_reg(CFG_MAX_ENTRY, ph == 0 ? 24'd2 : ph == 1 ? 24'd1 : 24'd4096);
            write_reg(CFG_MAX_PAYLOAD, ph == 0 ? 24'd40 : ph == 1 ? 24'd8388608 : POS_MAX);
            while (beats < (ph + 1) * 125) begin
                build_random();
                beats += pkt.size();
                send_packet(-1);
            end
        end

        wait_idle();
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
